// ===== rtl/core/vnh_pkg.sv =====
// ----------------------------------------------------------------------------
// vnh_pkg: value-noise heightmap shared definitions
// Field widths, fixed-point constants, hash multipliers and register codes.
// ----------------------------------------------------------------------------
package vnh_pkg;

    // Port widths
    localparam int PIX_W      = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register widths
    localparam int SEED_W    = 32;
    localparam int SCALE_W   = 24;
    localparam int OCTCNT_W  = 4;
    localparam int PERSIST_W = 16;

    // Fixed-point layout
    localparam int POS_FRAC = 16;
    localparam int POS_W    = PIX_W + SCALE_W;
    localparam int VAL_W    = 24;
    localparam int AMP_W    = 17;
    localparam int WGT_W    = 17;

    // Parameter defaults
    localparam int MAX_OCTAVES_DEF = 8;

    // Register reset values
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 24'd2048;
    localparam logic [OCTCNT_W-1:0]  OCTCNT_RST  = 4'd4;
    localparam logic [PERSIST_W-1:0] PERSIST_RST = 16'd32768;

    // Lattice hash constants
    localparam logic [31:0] HASH_X  = 32'h9E3779B1;
    localparam logic [31:0] HASH_Y  = 32'h85EBCA77;
    localparam logic [31:0] HASH_S  = 32'hC2B2AE3D;
    localparam logic [31:0] HASH_M1 = 32'h7FEB352D;
    localparam logic [31:0] HASH_M2 = 32'h846CA68B;

    // 1.0 in Q1.16 and 3.0 in Q2.16
    localparam logic [AMP_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0]      THREE_Q16 = 18'h30000;

    // Register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED    = 2'd0,
        REG_SCALE   = 2'd1,
        REG_OCTAVES = 2'd2,
        REG_PERSIST = 2'd3
    } cfg_reg_t;

endpackage

// ===== rtl/core/value_noise_heightmap_unit.sv =====
// ----------------------------------------------------------------------------
// value_noise_heightmap_unit: fractal value-noise height per pixel
// Fully pipelined fBm value noise: scale, lattice hash, smoothstep blend,
// octave accumulation and normalising division.
// ----------------------------------------------------------------------------
// One pixel transaction is taken every cycle while the pipeline is not halted and
// gives one height transaction. The path to the output buffer has seven stages
// for scaling, the lattice hash and the bilinear blend (all octaves in
// parallel lanes), one accumulation stage per octave, and a restoring divider
// that settles one quotient bit per stage. A two-entry output buffer lets the
// pipeline keep taking pixels while results wait; the pipeline halts only
// when that buffer is full and the last stage holds a result. Write the
// configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module value_noise_heightmap_unit #(
    parameter int MAX_OCTAVES = vnh_pkg::MAX_OCTAVES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vnh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vnh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [vnh_pkg::PIX_W-1:0]      pixel_x,
    input  logic [vnh_pkg::PIX_W-1:0]      pixel_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vnh_pkg::HEIGHT_W-1:0]   height
);
    import vnh_pkg::*;

    localparam int OCT    = MAX_OCTAVES;
    localparam int LOG_O  = $clog2(MAX_OCTAVES + 1);
    localparam int SUM_W  = 40 + LOG_O;
    localparam int NORM_W = AMP_W + LOG_O;
    localparam int DEN_W  = NORM_W + 8;
    localparam int QW     = HEIGHT_W;

    // Stage map
    localparam int ST_POS  = 0;
    localparam int ST_LAT  = 1;
    localparam int ST_BASE = 2;
    localparam int ST_MIX1 = 3;
    localparam int ST_MIX2 = 4;
    localparam int ST_EDGE = 5;
    localparam int ST_VAL  = 6;
    localparam int ST_ACC  = 7;
    localparam int ST_DIV  = ST_ACC + OCT;
    localparam int NSTG    = ST_DIV + QW;
    localparam int LAST    = NSTG - 1;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Smoothstep weight: t2 * (3 - 2t), Q0.16 in, Q1.16 out
    function automatic logic [WGT_W-1:0] fade(input logic [15:0] t2, input logic [15:0] t);
        logic [17:0] slope;
        logic [33:0] prod;
        slope = THREE_Q16 - {1'b0, t, 1'b0};
        prod  = 34'(t2) * 34'(slope);
        return prod[32:16];
    endfunction

    // Linear blend in Q0.24 with a Q1.16 weight
    function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b,
                                               input logic [WGT_W-1:0] s);
        logic [40:0] acc;
        acc = 41'(a) * 41'(ONE_Q16 - s) + 41'(b) * 41'(s);
        return acc[39:16];
    endfunction

    function automatic logic [31:0] fold16(input logic [31:0] h);
        return h ^ (h >> 16);
    endfunction

    function automatic logic [31:0] fold15(input logic [31:0] h);
        return h ^ (h >> 15);
    endfunction

    // Hash offset of each corner relative to (x0, y0)
    function automatic logic [31:0] corner_ofs(input logic [1:0] c);
        logic [31:0] r;
        unique case (c)
            2'd0:    r = 32'd0;
            2'd1:    r = HASH_X;
            2'd2:    r = HASH_Y;
            default: r = HASH_X + HASH_Y;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]           seed_mix_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [OCTCNT_W-1:0]   octcnt_reg;
    logic [PERSIST_W-1:0]  persist_reg;
    logic [4:0]            oct_req;
    logic [4:0]            oct_eff;

    // Keep the seed premultiplied; it only enters the hash as seed * HASH_S
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_mix_reg <= '0;
            scale_reg    <= SCALE_RST;
            octcnt_reg   <= OCTCNT_RST;
            persist_reg  <= PERSIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SEED:    seed_mix_reg <= cfg_data * HASH_S;
                REG_SCALE:   scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_OCTAVES: octcnt_reg   <= cfg_data[OCTCNT_W-1:0];
                REG_PERSIST: persist_reg  <= cfg_data[PERSIST_W-1:0];
            endcase
        end
    end

    // Clamp the octave count to 1 .. MAX_OCTAVES
    always_comb
    begin
        oct_req = 5'(octcnt_reg);
        priority if (oct_req == 5'd0)
            oct_eff = 5'd1;
        else if (oct_req > 5'(OCT))
            oct_eff = 5'(OCT);
        else
            oct_eff = oct_req;
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for all stages, output buffer decouples
    // ------------------------------------------------------------------
    logic [NSTG-1:0]     vld_reg;
    logic                adv;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic [QW-1:0]       hd_reg;
    logic [QW-1:0]       hd_next;
    logic [QW-1:0]       sk_reg;
    logic [QW-1:0]       sk_next;
    logic                push;
    logic                pop;

    assign adv      = !vld_reg[LAST] || (cnt_reg < 2'd2);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_x_reg, pos_y_reg;

    logic [31:0]      lat_ax_reg [OCT];
    logic [31:0]      lat_by_reg [OCT];
    logic [15:0]      lat_u_reg  [OCT];
    logic [15:0]      lat_v_reg  [OCT];
    logic [15:0]      lat_tu_reg [OCT];
    logic [15:0]      lat_tv_reg [OCT];
    logic [31:0]      lat_ax_next [OCT];
    logic [31:0]      lat_by_next [OCT];
    logic [15:0]      lat_u_next  [OCT];
    logic [15:0]      lat_v_next  [OCT];
    logic [15:0]      lat_tu_next [OCT];
    logic [15:0]      lat_tv_next [OCT];

    logic [31:0]      base_reg    [OCT];
    logic [WGT_W-1:0] base_su_reg [OCT];
    logic [WGT_W-1:0] base_sv_reg [OCT];
    logic [31:0]      base_next    [OCT];
    logic [WGT_W-1:0] base_su_next [OCT];
    logic [WGT_W-1:0] base_sv_next [OCT];

    logic [31:0]      mix1_reg    [OCT][4];
    logic [WGT_W-1:0] mix1_su_reg [OCT];
    logic [WGT_W-1:0] mix1_sv_reg [OCT];
    logic [31:0]      mix1_next   [OCT][4];

    logic [31:0]      mix2_reg    [OCT][4];
    logic [WGT_W-1:0] mix2_su_reg [OCT];
    logic [WGT_W-1:0] mix2_sv_reg [OCT];
    logic [31:0]      mix2_next   [OCT][4];

    logic [VAL_W-1:0] edge_top_reg [OCT];
    logic [VAL_W-1:0] edge_bot_reg [OCT];
    logic [WGT_W-1:0] edge_sv_reg  [OCT];
    logic [VAL_W-1:0] edge_top_next [OCT];
    logic [VAL_W-1:0] edge_bot_next [OCT];
    logic [VAL_W-1:0] crn [OCT][4];

    logic [VAL_W-1:0] val_reg  [OCT];
    logic [VAL_W-1:0] val_next [OCT];

    logic [VAL_W-1:0]  acc_val_reg  [OCT][OCT];
    logic [SUM_W-1:0]  acc_sum_reg  [OCT];
    logic [NORM_W-1:0] acc_norm_reg [OCT];
    logic [AMP_W-1:0]  acc_amp_reg  [OCT];
    logic [SUM_W-1:0]  acc_sum_next  [OCT];
    logic [NORM_W-1:0] acc_norm_next [OCT];
    logic [AMP_W-1:0]  acc_amp_next  [OCT];

    logic [SUM_W-1:0] div_rem_reg [QW];
    logic [DEN_W-1:0] div_den_reg [QW];
    logic [QW-1:0]    div_quo_reg [QW];
    logic [SUM_W-1:0] div_rem_next [QW];
    logic [DEN_W-1:0] div_den_next [QW];
    logic [QW-1:0]    div_quo_next [QW];

    // Lattice: coarsen the cell per octave, start the hash and the fade
    always_comb
    begin
        logic [31:0] xo;
        logic [31:0] yo;
        logic [31:0] sq;
        for (int o = 0; o < OCT; o++)
        begin
            xo = 32'(pos_x_reg >> (POS_FRAC + o));
            yo = 32'(pos_y_reg >> (POS_FRAC + o));
            lat_ax_next[o] = xo * HASH_X;
            lat_by_next[o] = yo * HASH_Y;
            // Octave fraction: ((cell mod 2^o) + frac) / 2^o in Q0.16
            lat_u_next[o]  = pos_x_reg[o +: 16];
            lat_v_next[o]  = pos_y_reg[o +: 16];
            sq             = 32'(lat_u_next[o]) * 32'(lat_u_next[o]);
            lat_tu_next[o] = sq[31:16];
            sq             = 32'(lat_v_next[o]) * 32'(lat_v_next[o]);
            lat_tv_next[o] = sq[31:16];
        end
    end

    // Base hash sum and smoothstep weights
    always_comb
    begin
        for (int o = 0; o < OCT; o++)
        begin
            base_next[o]    = lat_ax_reg[o] + lat_by_reg[o] + seed_mix_reg;
            base_su_next[o] = fade(lat_tu_reg[o], lat_u_reg[o]);
            base_sv_next[o] = fade(lat_tv_reg[o], lat_v_reg[o]);
        end
    end

    // Avalanche rounds for the four corners
    always_comb
    begin
        for (int o = 0; o < OCT; o++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mix1_next[o][c] = fold16(base_reg[o] + corner_ofs(2'(c))) * HASH_M1;
                mix2_next[o][c] = fold15(mix1_reg[o][c]) * HASH_M2;
            end
        end
    end

    // Finish the hash, mask to Q0.24 and blend along x, then along y
    always_comb
    begin
        logic [31:0] h;
        for (int o = 0; o < OCT; o++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                h         = fold16(mix2_reg[o][c]);
                crn[o][c] = h[VAL_W-1:0];
            end
            edge_top_next[o] = blend(crn[o][0], crn[o][1], mix2_su_reg[o]);
            edge_bot_next[o] = blend(crn[o][2], crn[o][3], mix2_su_reg[o]);
            val_next[o]      = blend(edge_top_reg[o], edge_bot_reg[o], edge_sv_reg[o]);
        end
    end

    // Octave accumulation: one octave per stage, amplitude falls per stage
    always_comb
    begin
        logic [SUM_W-1:0]  sum_in;
        logic [NORM_W-1:0] norm_in;
        logic [AMP_W-1:0]  amp_in;
        logic [VAL_W-1:0]  v_in;
        logic [40:0]       term;
        logic [32:0]       amp_prod;
        for (int j = 0; j < OCT; j++)
        begin
            if (j == 0)
            begin
                sum_in  = '0;
                norm_in = '0;
                amp_in  = ONE_Q16;
                v_in    = val_reg[0];
            end
            else
            begin
                sum_in  = acc_sum_reg[j-1];
                norm_in = acc_norm_reg[j-1];
                amp_in  = acc_amp_reg[j-1];
                v_in    = acc_val_reg[j-1][j];
            end
            term     = 41'(v_in) * 41'(amp_in);
            amp_prod = 33'(amp_in) * 33'(persist_reg);
            if (5'(j) < oct_eff)
            begin
                acc_sum_next[j]  = sum_in + SUM_W'(term);
                acc_norm_next[j] = norm_in + NORM_W'(amp_in);
            end
            else
            begin
                acc_sum_next[j]  = sum_in;
                acc_norm_next[j] = norm_in;
            end
            acc_amp_next[j] = amp_prod[32:16];
        end
    end

    // Restoring divider: sum / (norm * 256), one quotient bit per stage
    always_comb
    begin
        logic [SUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    quo_in;
        logic [SUM_W-1:0] trial;
        for (int i = 0; i < QW; i++)
        begin
            if (i == 0)
            begin
                rem_in = acc_sum_reg[OCT-1];
                den_in = {acc_norm_reg[OCT-1], 8'd0};
                quo_in = '0;
            end
            else
            begin
                rem_in = div_rem_reg[i-1];
                den_in = div_den_reg[i-1];
                quo_in = div_quo_reg[i-1];
            end
            trial           = SUM_W'(den_in) << (QW - 1 - i);
            div_den_next[i] = den_in;
            div_quo_next[i] = quo_in;
            if (rem_in >= trial)
            begin
                div_rem_next[i]             = rem_in - trial;
                div_quo_next[i][QW - 1 - i] = 1'b1;
            end
            else
                div_rem_next[i] = rem_in;
        end
    end

    // Advance every stage together; payload carries no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x_reg <= POS_W'(pixel_x) * POS_W'(scale_reg);
            pos_y_reg <= POS_W'(pixel_y) * POS_W'(scale_reg);
            for (int o = 0; o < OCT; o++)
            begin
                lat_ax_reg[o]   <= lat_ax_next[o];
                lat_by_reg[o]   <= lat_by_next[o];
                lat_u_reg[o]    <= lat_u_next[o];
                lat_v_reg[o]    <= lat_v_next[o];
                lat_tu_reg[o]   <= lat_tu_next[o];
                lat_tv_reg[o]   <= lat_tv_next[o];
                base_reg[o]     <= base_next[o];
                base_su_reg[o]  <= base_su_next[o];
                base_sv_reg[o]  <= base_sv_next[o];
                mix1_su_reg[o]  <= base_su_reg[o];
                mix1_sv_reg[o]  <= base_sv_reg[o];
                mix2_su_reg[o]  <= mix1_su_reg[o];
                mix2_sv_reg[o]  <= mix1_sv_reg[o];
                edge_sv_reg[o]  <= mix2_sv_reg[o];
                edge_top_reg[o] <= edge_top_next[o];
                edge_bot_reg[o] <= edge_bot_next[o];
                val_reg[o]      <= val_next[o];
                for (int c = 0; c < 4; c++)
                begin
                    mix1_reg[o][c] <= mix1_next[o][c];
                    mix2_reg[o][c] <= mix2_next[o][c];
                end
            end
            for (int j = 0; j < OCT; j++)
            begin
                acc_sum_reg[j]  <= acc_sum_next[j];
                acc_norm_reg[j] <= acc_norm_next[j];
                acc_amp_reg[j]  <= acc_amp_next[j];
                for (int o = 0; o < OCT; o++)
                begin
                    if (j == 0)
                        acc_val_reg[j][o] <= val_reg[o];
                    else
                        acc_val_reg[j][o] <= acc_val_reg[j-1][o];
                end
            end
            for (int i = 0; i < QW; i++)
            begin
                div_rem_reg[i] <= div_rem_next[i];
                div_den_reg[i] <= div_den_next[i];
                div_quo_reg[i] <= div_quo_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: head register plus one skid entry
    // ------------------------------------------------------------------
    assign push      = adv && vld_reg[LAST];
    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign height    = hd_reg;

    always_comb
    begin
        hd_next  = hd_reg;
        sk_next  = sk_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        priority if (cnt_reg == 2'd2)
        begin
            // Full: drain the skid entry into the head
            if (pop)
                hd_next = sk_reg;
        end
        else if ((cnt_reg == 2'd0) || pop)
        begin
            if (push)
                hd_next = div_quo_reg[QW-1];
        end
        else if (push)
            sk_next = div_quo_reg[QW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        hd_reg <= hd_next;
        sk_reg <= sk_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer over capacity");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAST] && (cnt_reg == 2'd2) && !out_ready)
        |=> (vld_reg[LAST] && $stable(div_quo_reg[QW-1])))
        else $error("result lost while output buffer full");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV-1] |-> (acc_norm_reg[OCT-1] != '0))
        else $error("amplitude total is zero");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] |-> (div_rem_reg[QW-1] < SUM_W'(div_den_reg[QW-1])))
        else $error("divider remainder not below divisor");

endmodule
